FILE: rtl/tfp_pkg.sv
package tfp_pkg;

   // Characters of the frame header and trailer.
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_ONE     = 8'h31;
   localparam logic [7:0] CH_FOUR    = 8'h34;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] DIGIT_BASE = 8'd49;

   // Result status codes.
   localparam logic [1:0] ST_DATA        = 2'd0;
   localparam logic [1:0] ST_BAD_STATION = 2'd1;
   localparam logic [1:0] ST_BAD_HEADER  = 2'd2;
   localparam logic [1:0] ST_BAD_TRAIL   = 2'd3;

   // Depth of the command queue between the parser and the emitter.
   localparam int unsigned QUEUE_DEPTH = 2;

   // Parser phases.
   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_STATION = 3'd1,
      PH_SPACE   = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CLOSE   = 3'd4
   } phase_type;

   // One command for the emitter: an error result, or a whole frame in a bank.
   typedef struct packed {
      logic [1:0] status;
      logic [1:0] station;
      logic       bank;
   } cmd_type;

   // Release of a payload bank once its last word has left the store.
   typedef struct packed {
      logic valid;
      logic bank;
   } rel_type;

endpackage

FILE: rtl/tfp_front.sv
module tfp_front #(
   parameter int unsigned WORDS = 7,
   parameter int unsigned IDX_W = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   input  logic                 q_ready,
   output logic                 q_push,
   output tfp_pkg::cmd_type     q_cmd,
   input  tfp_pkg::rel_type     rel,
   input  logic                 rd_bank,
   input  logic [IDX_W-1:0]     rd_idx,
   output logic [31:0]          rd_data
);

   tfp_pkg::phase_type phase_ff, phase_in;
   logic [1:0]         station_ff, station_in;
   logic               bank_ff, bank_in;
   logic [1:0]         byte_sel_ff, byte_sel_in;
   logic [IDX_W-1:0]   widx_ff, widx_in;
   logic [31:0]        word_ff, word_in;
   logic [1:0]         busy_ff, busy_in;
   logic [31:0]        store_ff [2][WORDS];
   logic               wr_en;
   logic               accept;
   logic [7:0]         digit_diff;
   logic [1:0]         set_mask, clr_mask;

   // A payload byte may only land in a bank that the emitter has released.
   assign req_ready = q_ready &&
                      !(phase_ff == tfp_pkg::PH_PAYLOAD && busy_ff[bank_ff]);
   assign accept     = req_valid && req_ready;
   assign digit_diff = req_rx_byte - tfp_pkg::DIGIT_BASE;

   // Phase decoding of each accepted beat.
   always_comb begin
      phase_in    = phase_ff;
      station_in  = station_ff;
      bank_in     = bank_ff;
      byte_sel_in = byte_sel_ff;
      widx_in     = widx_ff;
      word_in     = word_ff;
      wr_en       = 1'b0;
      set_mask    = 2'b00;
      q_push      = 1'b0;
      q_cmd       = '{status: tfp_pkg::ST_DATA, station: station_ff, bank: bank_ff};
      if (accept) begin
         unique case (phase_ff)
            tfp_pkg::PH_HUNT: begin
               if (req_rx_byte == tfp_pkg::CH_ZERO) begin
                  phase_in = tfp_pkg::PH_STATION;
               end
            end
            tfp_pkg::PH_STATION: begin
               if (req_rx_byte >= tfp_pkg::CH_ONE && req_rx_byte <= tfp_pkg::CH_FOUR) begin
                  station_in = digit_diff[1:0];
                  phase_in   = tfp_pkg::PH_SPACE;
               end else begin
                  q_push        = 1'b1;
                  q_cmd.status  = tfp_pkg::ST_BAD_STATION;
                  q_cmd.station = 2'd0;
                  phase_in      = tfp_pkg::PH_HUNT;
               end
            end
            tfp_pkg::PH_SPACE: begin
               if (req_rx_byte == tfp_pkg::CH_SPACE) begin
                  byte_sel_in = 2'd0;
                  widx_in     = '0;
                  phase_in    = tfp_pkg::PH_PAYLOAD;
               end else begin
                  q_push       = 1'b1;
                  q_cmd.status = tfp_pkg::ST_BAD_HEADER;
                  phase_in     = tfp_pkg::PH_HUNT;
               end
            end
            tfp_pkg::PH_PAYLOAD: begin
               // Bytes shift in from the top so the first one ends up lowest.
               word_in     = {req_rx_byte, word_ff[31:8]};
               byte_sel_in = byte_sel_ff + 2'd1;
               if (byte_sel_ff == 2'd3) begin
                  wr_en   = 1'b1;
                  widx_in = widx_ff + IDX_W'(1);
                  if (widx_ff == IDX_W'(WORDS - 1)) begin
                     phase_in = tfp_pkg::PH_CLOSE;
                  end
               end
            end
            tfp_pkg::PH_CLOSE: begin
               q_push = 1'b1;
               if (req_rx_byte == tfp_pkg::CH_SPACE) begin
                  q_cmd.status = tfp_pkg::ST_DATA;
                  set_mask     = 2'b01 << bank_ff;
                  bank_in      = ~bank_ff;
               end else begin
                  q_cmd.status = tfp_pkg::ST_BAD_TRAIL;
               end
               phase_in = tfp_pkg::PH_HUNT;
            end
            default: begin
               phase_in = tfp_pkg::PH_HUNT;
            end
         endcase
      end
   end

   // Bank occupancy: set when a frame is queued, cleared when it is drained.
   always_comb begin
      clr_mask = rel.valid ? (2'b01 << rel.bank) : 2'b00;
      busy_in  = (busy_ff & ~clr_mask) | set_mask;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= tfp_pkg::PH_HUNT;
         station_ff <= 2'd0;
         bank_ff    <= 1'b0;
         busy_ff    <= 2'b00;
      end else begin
         phase_ff   <= phase_in;
         station_ff <= station_in;
         bank_ff    <= bank_in;
         busy_ff    <= busy_in;
      end
   end

   // Payload assembly registers.
   always_ff @(posedge clock) begin
      byte_sel_ff <= byte_sel_in;
      widx_ff     <= widx_in;
      word_ff     <= word_in;
   end

   // Two-bank word store, one bank filling while the other drains.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[bank_ff][widx_ff] <= {req_rx_byte, word_ff[31:8]};
      end
   end

   assign rd_data = store_ff[rd_bank][rd_idx];

endmodule

FILE: rtl/tfp_queue.sv
module tfp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tfp_pkg::cmd_type push_cmd,
   output logic             push_ready,
   input  logic             pop,
   output logic             head_valid,
   output tfp_pkg::cmd_type head_cmd
);

   localparam int unsigned PTR_W = (tfp_pkg::QUEUE_DEPTH > 1) ?
                                   $clog2(tfp_pkg::QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(tfp_pkg::QUEUE_DEPTH + 1);

   tfp_pkg::cmd_type entry_ff [tfp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff < CNT_W'(tfp_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   // Pointer and fill level update with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(tfp_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(tfp_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/tfp_back.sv
module tfp_back #(
   parameter int unsigned WORDS = 7,
   parameter int unsigned IDX_W = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  tfp_pkg::cmd_type head_cmd,
   output logic             pop,
   output tfp_pkg::rel_type rel,
   output logic             rd_bank,
   output logic [IDX_W-1:0] rd_idx,
   input  logic [31:0]      rd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [1:0]       rsp_station,
   output logic [2:0]       rsp_word_index,
   output logic [31:0]      rsp_word_value,
   output logic             rsp_last
);

   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   logic [1:0]       status_ff, station_ff;
   logic [2:0]       index_ff;
   logic [31:0]      value_ff;
   logic             last_ff;
   logic             load, is_err, last_word;
   logic [IDX_W+2:0] cnt_ext;

   // A result is loaded whenever the output beat is empty or being taken.
   assign load      = head_valid && (!valid_ff || rsp_ready);
   assign is_err    = head_cmd.status != tfp_pkg::ST_DATA;
   assign last_word = cnt_ff == IDX_W'(WORDS - 1);
   assign pop       = load && (is_err || last_word);
   assign rel.valid = load && !is_err && last_word;
   assign rel.bank  = head_cmd.bank;
   assign rd_bank   = head_cmd.bank;
   assign rd_idx    = cnt_ff;
   assign cnt_ext   = {3'b000, cnt_ff};

   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         if (!is_err) begin
            cnt_in = last_word ? '0 : cnt_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   // Output beat register.
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff  <= head_cmd.status;
         station_ff <= head_cmd.station;
         if (is_err) begin
            index_ff <= 3'd0;
            value_ff <= 32'd0;
            last_ff  <= 1'b1;
         end else begin
            index_ff <= cnt_ext[2:0];
            value_ff <= rd_data;
            last_ff  <= last_word;
         end
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_station    = station_ff;
   assign rsp_word_index = index_ff;
   assign rsp_word_value = value_ff;
   assign rsp_last       = last_ff;

endmodule

FILE: rtl/tracker_frame_parser.sv
// Frame parser for a motion tracker's serial stream. One received byte is
// taken per cycle: the parser hunts for '0', checks a station digit '1'..'4'
// and a space, packs the payload bytes little endian into 32-bit words and
// checks the closing space. A good frame yields WORDS_PER_FRAME result beats,
// one per cycle while rsp_ready is high, tagged with the station and marked
// last on the final word; a bad digit or separator yields a single error beat
// with last set, and hunting resumes. Input throughput is one byte per cycle
// with two causes of stall: the payload store has two banks, so a new frame's
// payload bytes stall while both banks hold frames that have not yet been
// drained, and any byte stalls while the two-entry command queue between the
// parser and the result emitter is full. The result beat is registered.
module tracker_frame_parser #(
   parameter int unsigned WORDS_PER_FRAME = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_station,
   output logic [2:0]  rsp_word_index,
   output logic [31:0] rsp_word_value,
   output logic        rsp_last
);

   localparam int unsigned IDX_W = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;

   logic             q_push, q_ready, q_pop, q_head_valid;
   tfp_pkg::cmd_type q_cmd, q_head;
   tfp_pkg::rel_type rel;
   logic             rd_bank;
   logic [IDX_W-1:0] rd_idx;
   logic [31:0]      rd_data;

   // Byte parser and payload store.
   tfp_front #(
      .WORDS (WORDS_PER_FRAME),
      .IDX_W (IDX_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_ready     (q_ready),
      .q_push      (q_push),
      .q_cmd       (q_cmd),
      .rel         (rel),
      .rd_bank     (rd_bank),
      .rd_idx      (rd_idx),
      .rd_data     (rd_data)
   );

   // Command queue between parser and emitter.
   tfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_cmd   (q_head)
   );

   // Result emitter.
   tfp_back #(
      .WORDS (WORDS_PER_FRAME),
      .IDX_W (IDX_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_head_valid),
      .head_cmd       (q_head),
      .pop            (q_pop),
      .rel            (rel),
      .rd_bank        (rd_bank),
      .rd_idx         (rd_idx),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_station    (rsp_station),
      .rsp_word_index (rsp_word_index),
      .rsp_word_value (rsp_word_value),
      .rsp_last       (rsp_last)
   );

endmodule
